@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ rtl/core/esvt_pkg.sv @@
// Shared types, constants and sine table function for the view transform.
// No dependencies.
`timescale 1ns / 1ps
package esvt_pkg;

  localparam int unsigned Frac = 12;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic signed [15:0] OneQ12 = 16'sd4096;

  typedef logic signed [13:0] trig_t;
  typedef logic signed [19:0] mval_t;

  typedef enum logic [2:0] {
    CfgRotRow0  = 3'd0,
    CfgRotRow1  = 3'd1,
    CfgRotRow2  = 3'd2,
    CfgTransX   = 3'd3,
    CfgTransY   = 3'd4,
    CfgTransZ   = 3'd5
  } cfg_idx_e;

  // 1.12 sine of a Q30 angle in [0, pi/2], eight-term Taylor series.
  function automatic logic [12:0] qsin_q12(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] res;
    logic signed [63:0] acc;
    x2 = (x * x) >> 30;
    term = x;
    acc = signed'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    res = ((64'(acc) * 64'd4096) + (64'd1 << 29)) >> 30;
    return res[12:0];
  endfunction

endpackage

@@ rtl/core/esvt_sin_rom.sv @@
// Quarter-wave 1.12 sine ROM, two registered read ports.
// Depends on esvt_pkg (table function).
`timescale 1ns / 1ps
module esvt_sin_rom
  import esvt_pkg::*;
#(
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] addr_a_i,
  input  logic [AddrW-1:0] addr_b_i,
  output logic [12:0]      data_a_o,
  output logic [12:0]      data_b_o
);

  logic [12:0] rom_w [Depth+1];

  for (genvar i = 0; i <= Depth; i++) begin : g_tab
    localparam logic [63:0] AngQ30 = (HalfPiQ30 * 64'(i)) / 64'(Depth);
    assign rom_w[i] = qsin_q12(AngQ30);
  end

  always_ff @(posedge clk_i) begin
    data_a_o <= rom_w[addr_a_i];
    data_b_o <= rom_w[addr_b_i];
  end

endmodule

@@ rtl/core/esvt_trig.sv @@
// Sine and cosine lookup for three angles: address stage plus ROM stage.
// Depends on esvt_pkg and esvt_sin_rom.
`timescale 1ns / 1ps
module esvt_trig
  import esvt_pkg::*;
#(
  parameter int unsigned Depth = 1024
) (
  input  logic        clk_i,
  input  logic [11:0] angle_i [3],
  output trig_t       sin_o   [3],
  output trig_t       cos_o   [3]
);

  localparam int unsigned AddrW = $clog2(Depth + 1);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [AddrW+9:0] scaled_w;
    logic [AddrW-1:0] idx_w;
    logic [AddrW-1:0] addr_s_q, addr_c_q;
    logic             neg_s_q, neg_c_q, neg_s2_q, neg_c2_q;
    logic [12:0]      ds_w, dc_w;

    assign scaled_w = (AddrW + 10)'(angle_i[a][9:0]) * (AddrW + 10)'(Depth);
    assign idx_w    = scaled_w[AddrW+9:10];

    // cos(a) = sin(a + quarter turn): same index, next quadrant
    always_ff @(posedge clk_i) begin
      addr_s_q <= angle_i[a][10] ? AddrW'(Depth) - idx_w : idx_w;
      addr_c_q <= angle_i[a][10] ? idx_w : AddrW'(Depth) - idx_w;
      neg_s_q  <= angle_i[a][11];
      neg_c_q  <= angle_i[a][11] ^ angle_i[a][10];
      neg_s2_q <= neg_s_q;
      neg_c2_q <= neg_c_q;
    end

    esvt_sin_rom #(.Depth(Depth)) u_rom (
      .clk_i    (clk_i),
      .addr_a_i (addr_s_q),
      .addr_b_i (addr_c_q),
      .data_a_o (ds_w),
      .data_b_o (dc_w)
    );

    assign sin_o[a] = neg_s2_q ? -trig_t'({1'b0, ds_w}) : trig_t'({1'b0, ds_w});
    assign cos_o[a] = neg_c2_q ? -trig_t'({1'b0, dc_w}) : trig_t'({1'b0, dc_w});
  end

endmodule

@@ rtl/core/esvt_rot.sv @@
// Euler rotation Rz*Ry*Rx and column scaling, three register stages.
// Depends on esvt_pkg.
`timescale 1ns / 1ps
module esvt_rot
  import esvt_pkg::*;
(
  input  logic                clk_i,
  input  trig_t               sin_i   [3],
  input  trig_t               cos_i   [3],
  input  logic signed [15:0]  scale_i [3],
  output mval_t               m_o     [3][3]
);

  function automatic logic signed [15:0] mul_tt(input trig_t a, input trig_t b);
    logic signed [27:0] p;
    p = a * b;
    return p[27:12];
  endfunction

  function automatic logic signed [17:0] mul_rt(input logic signed [15:0] a,
                                                input trig_t b);
    logic signed [29:0] p;
    p = a * b;
    return p[29:12];
  endfunction

  logic signed [15:0] czcy_q, czsy_q, szcy_q, szsy_q, szcx_q, szsx_q;
  logic signed [15:0] czcx_q, czsx_q, cysx_q, cycx_q;
  trig_t              sx_q, cx_q, sy_q;
  logic signed [15:0] r_q [3][3];

  always_ff @(posedge clk_i) begin
    czcy_q <= mul_tt(cos_i[2], cos_i[1]);
    czsy_q <= mul_tt(cos_i[2], sin_i[1]);
    szcy_q <= mul_tt(sin_i[2], cos_i[1]);
    szsy_q <= mul_tt(sin_i[2], sin_i[1]);
    szcx_q <= mul_tt(sin_i[2], cos_i[0]);
    szsx_q <= mul_tt(sin_i[2], sin_i[0]);
    czcx_q <= mul_tt(cos_i[2], cos_i[0]);
    czsx_q <= mul_tt(cos_i[2], sin_i[0]);
    cysx_q <= mul_tt(cos_i[1], sin_i[0]);
    cycx_q <= mul_tt(cos_i[1], cos_i[0]);
    sx_q   <= sin_i[0];
    cx_q   <= cos_i[0];
    sy_q   <= sin_i[1];
  end

  always_ff @(posedge clk_i) begin
    r_q[0][0] <= czcy_q;
    r_q[0][1] <= 16'(mul_rt(czsy_q, sx_q) - 18'(szcx_q));
    r_q[0][2] <= 16'(mul_rt(czsy_q, cx_q) + 18'(szsx_q));
    r_q[1][0] <= szcy_q;
    r_q[1][1] <= 16'(mul_rt(szsy_q, sx_q) + 18'(czcx_q));
    r_q[1][2] <= 16'(mul_rt(szsy_q, cx_q) - 18'(czsx_q));
    r_q[2][0] <= -(16'(sy_q));
    r_q[2][1] <= cysx_q;
    r_q[2][2] <= cycx_q;
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [31:0] p_w;
      assign p_w = r_q[i][j] * scale_i[j];
      always_ff @(posedge clk_i) begin
        m_o[i][j] <= p_w[31:12];
      end
    end
  end

endmodule

@@ rtl/core/esvt_cam.sv @@
// Camera stage: view rotation and translation, product and sum stages.
// Depends on esvt_pkg.
`timescale 1ns / 1ps
module esvt_cam
  import esvt_pkg::*;
(
  input  logic               clk_i,
  input  mval_t              m_i         [3][3],
  input  logic signed [15:0] pos_i       [3],
  input  logic [47:0]        cam_rot_i   [3],
  input  logic signed [31:0] cam_trans_i [3],
  output logic signed [30:0] view_r_o    [3][3],
  output logic signed [47:0] view_t_o    [3]
);

  logic signed [23:0] pr_q [3][3][3];
  logic signed [31:0] pt_q [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_k
      logic signed [15:0] c_w;
      logic signed [31:0] ptw;
      assign c_w = signed'(cam_rot_i[i][16*k +: 16]);
      assign ptw = c_w * pos_i[k];
      always_ff @(posedge clk_i) begin
        pt_q[i][k] <= ptw;
      end
      for (genvar j = 0; j < 3; j++) begin : g_col
        logic signed [35:0] p_w;
        assign p_w = c_w * m_i[k][j];
        always_ff @(posedge clk_i) begin
          pr_q[i][j][k] <= p_w[35:12];
        end
      end
    end

    // sums stay well inside the field ranges, so no clamp is needed
    for (genvar j = 0; j < 3; j++) begin : g_sum
      always_ff @(posedge clk_i) begin
        view_r_o[i][j] <= 31'(pr_q[i][j][0]) + 31'(pr_q[i][j][1]) + 31'(pr_q[i][j][2]);
      end
    end

    always_ff @(posedge clk_i) begin
      view_t_o[i] <= (48'(cam_trans_i[i]) <<< Frac) + 48'(pt_q[i][0])
                     + 48'(pt_q[i][1]) + 48'(pt_q[i][2]);
    end
  end

endmodule

@@ rtl/core/euler_scale_view_transform.sv @@
// Top level: node euler/scale/position to view transform, 7-stage pipeline.
// Depends on esvt_pkg, esvt_trig, esvt_rot, esvt_cam and assert_macros.svh.
//
// Usage:
//   Pulse start_i with angles, scales and position; a transfer happens at a
//   clock edge with start_i high and busy_o low. busy_o stays low, so a new
//   node may be started every cycle (one node per clock).
//   Each result comes out of the pipeline with done_o high for exactly one
//   cycle; results come out in start order.
//   The pipeline stages are angle addressing, sine ROM read, trig
//   products, rotation, column scaling, camera products, camera sums.
//   The receiver cannot stall; it must take each result while done_o is high.
//   Camera registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
//   the user must do so only while no node is in flight, as the block does
//   not enforce it; indexes 6 and 7 are ignored. Reset empties the pipeline
//   and loads an identity camera with zero translation.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euler_scale_view_transform
  import esvt_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] angle_x_i,
  input  logic signed [15:0] angle_y_i,
  input  logic signed [15:0] angle_z_i,
  input  logic signed [15:0] scale_x_i,
  input  logic signed [15:0] scale_y_i,
  input  logic signed [15:0] scale_z_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [30:0] view_r00_o,
  output logic signed [30:0] view_r01_o,
  output logic signed [30:0] view_r02_o,
  output logic signed [30:0] view_r10_o,
  output logic signed [30:0] view_r11_o,
  output logic signed [30:0] view_r12_o,
  output logic signed [30:0] view_r20_o,
  output logic signed [30:0] view_r21_o,
  output logic signed [30:0] view_r22_o,
  output logic signed [47:0] view_tx_o,
  output logic signed [47:0] view_ty_o,
  output logic signed [47:0] view_tz_o
);

  localparam int unsigned Stages = 7;
  localparam int unsigned SideStages = 5;

  logic [47:0]        cam_rot_q   [3];
  logic signed [31:0] cam_trans_q [3];
  logic [Stages-1:0]  vld_q;
  logic signed [15:0] scale_q [SideStages][3];
  logic signed [15:0] pos_q   [SideStages][3];
  logic               unset_w;
  logic               accept_w;
  logic [11:0]        angle_w [3];
  trig_t              sin_w [3];
  trig_t              cos_w [3];
  mval_t              m_w [3][3];
  logic signed [30:0] view_r_w [3][3];
  logic signed [47:0] view_t_w [3];

  assign busy_o   = 1'b0;
  assign accept_w = start_i & ~busy_o;
  assign unset_w  = (scale_x_i == '0) && (scale_y_i == '0) && (scale_z_i == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_rot_q[0]   <= 48'd4096;
      cam_rot_q[1]   <= 48'd4096 << 16;
      cam_rot_q[2]   <= 48'd4096 << 32;
      cam_trans_q[0] <= '0;
      cam_trans_q[1] <= '0;
      cam_trans_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRotRow0: cam_rot_q[0] <= cfg_wdata_i;
        CfgRotRow1: cam_rot_q[1] <= cfg_wdata_i;
        CfgRotRow2: cam_rot_q[2] <= cfg_wdata_i;
        CfgTransX:  cam_trans_q[0] <= signed'(cfg_wdata_i[31:0]);
        CfgTransY:  cam_trans_q[1] <= signed'(cfg_wdata_i[31:0]);
        CfgTransZ:  cam_trans_q[2] <= signed'(cfg_wdata_i[31:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], accept_w};
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q[0][0] <= unset_w ? OneQ12 : scale_x_i;
    scale_q[0][1] <= unset_w ? OneQ12 : scale_y_i;
    scale_q[0][2] <= unset_w ? OneQ12 : scale_z_i;
    pos_q[0][0]   <= pos_x_i;
    pos_q[0][1]   <= pos_y_i;
    pos_q[0][2]   <= pos_z_i;
    for (int s = 1; s < SideStages; s++) begin
      scale_q[s] <= scale_q[s-1];
      pos_q[s]   <= pos_q[s-1];
    end
  end

  assign angle_w[0] = angle_x_i[11:0];
  assign angle_w[1] = angle_y_i[11:0];
  assign angle_w[2] = angle_z_i[11:0];

  esvt_trig #(.Depth(SINE_TABLE_DEPTH)) u_trig (
    .clk_i   (clk_i),
    .angle_i (angle_w),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  esvt_rot u_rot (
    .clk_i   (clk_i),
    .sin_i   (sin_w),
    .cos_i   (cos_w),
    .scale_i (scale_q[3]),
    .m_o     (m_w)
  );

  esvt_cam u_cam (
    .clk_i       (clk_i),
    .m_i         (m_w),
    .pos_i       (pos_q[4]),
    .cam_rot_i   (cam_rot_q),
    .cam_trans_i (cam_trans_q),
    .view_r_o    (view_r_w),
    .view_t_o    (view_t_w)
  );

  assign done_o     = vld_q[Stages-1];
  assign view_r00_o = view_r_w[0][0];
  assign view_r01_o = view_r_w[0][1];
  assign view_r02_o = view_r_w[0][2];
  assign view_r10_o = view_r_w[1][0];
  assign view_r11_o = view_r_w[1][1];
  assign view_r12_o = view_r_w[1][2];
  assign view_r20_o = view_r_w[2][0];
  assign view_r21_o = view_r_w[2][1];
  assign view_r22_o = view_r_w[2][2];
  assign view_tx_o  = view_t_w[0];
  assign view_ty_o  = view_t_w[1];
  assign view_tz_o  = view_t_w[2];

  `ASSERT_PROP(a_start_to_done, clk_i, rst_ni, accept_w |-> ##7 done_o, "transfer lost")
  `ASSERT_PROP(a_done_has_start, clk_i, rst_ni, done_o |-> $past(start_i, 7), "spurious result")
  `ASSERT_NEVER(a_busy_low, clk_i, rst_ni, busy_o && start_i, "start refused")

endmodule

@@ test/esvt_checker.sv @@
// Watches the node and view-transform channels of the view transform block,
// predicts each view matrix and translation, and counts mismatches.
// Depends on esvt_pkg.
`timescale 1ns / 1ps
module esvt_checker
  import esvt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [15:0] angle_x_i,
  input  logic signed [15:0] angle_y_i,
  input  logic signed [15:0] angle_z_i,
  input  logic signed [15:0] scale_x_i,
  input  logic signed [15:0] scale_y_i,
  input  logic signed [15:0] scale_z_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_wdata_i,
  input  logic               done_i,
  input  logic signed [30:0] view_r_i [9],
  input  logic signed [47:0] view_t_i [3],
  output int                 fail_cnt_o,
  output int                 pending_o
);

  localparam int unsigned TableDepth = 1024;

  typedef struct {
    logic signed [30:0] r [9];
    logic signed [47:0] t [3];
  } view_xform_t;

  logic [47:0]        cam_row_q [3];
  logic signed [31:0] cam_trans_q [3];
  view_xform_t        expected_q [$];

  function automatic longint floor12(longint v);
    return v >>> 12;
  endfunction

  function automatic longint sine_entry(longint i);
    longint unsigned x, x2, term;
    longint sum;
    if (i > TableDepth) i = TableDepth;
    x = 64'd1686629713 * 64'(i) / TableDepth;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'((64'(sum) * 64'd4096 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint sine_q12(logic [15:0] ang);
    logic [11:0] a;
    longint idx, v;
    a = ang[11:0];
    idx = longint'(a[9:0]) * TableDepth / 1024;
    v = (a[11:10] == 2'd0 || a[11:10] == 2'd2) ? sine_entry(idx)
                                                 : sine_entry(TableDepth - idx);
    return a[11] ? -v : v;
  endfunction

  function automatic longint sat(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic view_xform_t predict_view(logic signed [15:0] ang [3],
                                               logic signed [15:0] scl [3],
                                               logic signed [15:0] pos [3]);
    view_xform_t res;
    longint sx, cx, sy, cy, sz, cz, tmp, acc;
    longint rot [3][3];
    longint msc [3][3];
    longint cam [3][3];
    longint s [3];
    sx = sine_q12(ang[0]); cx = sine_q12(ang[0] + 16'd1024);
    sy = sine_q12(ang[1]); cy = sine_q12(ang[1] + 16'd1024);
    sz = sine_q12(ang[2]); cz = sine_q12(ang[2] + 16'd1024);
    rot[0][0] = floor12(cz * cy);
    tmp = floor12(cz * sy);
    rot[0][1] = floor12(tmp * sx) - floor12(sz * cx);
    rot[0][2] = floor12(tmp * cx) + floor12(sz * sx);
    rot[1][0] = floor12(sz * cy);
    tmp = floor12(sz * sy);
    rot[1][1] = floor12(tmp * sx) + floor12(cz * cx);
    rot[1][2] = floor12(tmp * cx) - floor12(cz * sx);
    rot[2][0] = -sy;
    rot[2][1] = floor12(cy * sx);
    rot[2][2] = floor12(cy * cx);
    for (int j = 0; j < 3; j++) s[j] = scl[j];
    if (s[0] == 0 && s[1] == 0 && s[2] == 0) s = '{4096, 4096, 4096};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        msc[i][j] = floor12(rot[i][j] * s[j]);
        cam[i][j] = longint'($signed(cam_row_q[i][16*j +: 16]));
      end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += floor12(cam[i][k] * msc[k][j]);
        res.r[3*i+j] = 31'(sat(acc, 31));
      end
      acc = longint'(cam_trans_q[i]) * 4096;
      for (int k = 0; k < 3; k++) acc += cam[i][k] * longint'(pos[k]);
      res.t[i] = 48'(sat(acc, 48));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    view_xform_t exp_v;
    int errs;
    if (!rst_ni) begin
      cam_row_q <= '{48'd4096, 48'd4096 << 16, 48'd4096 << 32};
      cam_trans_q <= '{default: '0};
      expected_q.delete();
      fail_cnt_o <= 0;
    end else begin
      errs = 0;
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected view transform transfer");
          errs++;
        end else begin
          exp_v = expected_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (view_r_i[i] !== exp_v.r[i]) begin
              $error("view_r%0d%0d exp %0d got %0d", i / 3, i % 3, exp_v.r[i], view_r_i[i]);
              errs++;
            end
          for (int i = 0; i < 3; i++)
            if (view_t_i[i] !== exp_v.t[i]) begin
              $error("view_t%s exp %0d got %0d", i == 0 ? "x" : (i == 1 ? "y" : "z"),
                     exp_v.t[i], view_t_i[i]);
              errs++;
            end
        end
      end
      fail_cnt_o <= fail_cnt_o + errs;
      if (start_i && !busy_i)
        expected_q.push_back(predict_view('{angle_x_i, angle_y_i, angle_z_i},
                                          '{scale_x_i, scale_y_i, scale_z_i},
                                          '{pos_x_i, pos_y_i, pos_z_i}));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgRotRow0: cam_row_q[0] <= cfg_wdata_i;
          CfgRotRow1: cam_row_q[1] <= cfg_wdata_i;
          CfgRotRow2: cam_row_q[2] <= cfg_wdata_i;
          CfgTransX:  cam_trans_q[0] <= cfg_wdata_i[31:0];
          CfgTransY:  cam_trans_q[1] <= cfg_wdata_i[31:0];
          CfgTransZ:  cam_trans_q[2] <= cfg_wdata_i[31:0];
          default: ;
        endcase
      end
    end
  end

  assign pending_o = expected_q.size();

endmodule

@@ test/euler_scale_view_transform_tb.sv @@
// Stimulus and verdict for the view transform block: camera settings,
// directed and random node transfers under varying idle patterns.
// Depends on esvt_pkg, esvt_checker and the block.
`timescale 1ns / 1ps
module euler_scale_view_transform_tb;
  import esvt_pkg::*;

  logic               clk, rst_n, start, busy, cfg_we, done;
  logic signed [15:0] ang [3];
  logic signed [15:0] scl [3];
  logic signed [15:0] pos [3];
  logic [2:0]         cfg_idx;
  logic [47:0]        cfg_wdata;
  logic signed [30:0] view_r [9];
  logic signed [47:0] view_t [3];
  int                 fail_cnt, pending;
  int                 idle_pct;

  euler_scale_view_transform i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .angle_x_i(ang[0]), .angle_y_i(ang[1]), .angle_z_i(ang[2]),
    .scale_x_i(scl[0]), .scale_y_i(scl[1]), .scale_z_i(scl[2]),
    .pos_x_i(pos[0]), .pos_y_i(pos[1]), .pos_z_i(pos[2]),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .done_o(done),
    .view_r00_o(view_r[0]), .view_r01_o(view_r[1]), .view_r02_o(view_r[2]),
    .view_r10_o(view_r[3]), .view_r11_o(view_r[4]), .view_r12_o(view_r[5]),
    .view_r20_o(view_r[6]), .view_r21_o(view_r[7]), .view_r22_o(view_r[8]),
    .view_tx_o(view_t[0]), .view_ty_o(view_t[1]), .view_tz_o(view_t[2])
  );

  esvt_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .angle_x_i(ang[0]), .angle_y_i(ang[1]), .angle_z_i(ang[2]),
    .scale_x_i(scl[0]), .scale_y_i(scl[1]), .scale_z_i(scl[2]),
    .pos_x_i(pos[0]), .pos_y_i(pos[1]), .pos_z_i(pos[2]),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .done_i(done), .view_r_i(view_r), .view_t_i(view_t),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_node(logic [15:0] a [3], logic [15:0] s [3], logic [15:0] p [3]);
    cfg_we <= 1'b0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    for (int i = 0; i < 3; i++) begin
      ang[i] <= a[i]; scl[i] <= s[i]; pos[i] <= p[i];
    end
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_random_node();
    logic [15:0] a [3], s [3], p [3];
    for (int i = 0; i < 3; i++) begin
      a[i] = 16'($urandom);
      p[i] = 16'($urandom);
      case ($urandom_range(3))
        0: s[i] = 16'($urandom);
        1: s[i] = 16'($urandom_range(8192));
        2: s[i] = 16'sd4096;
        default: s[i] = '0;
      endcase
    end
    send_node(a, s, p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [47:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic write_raw(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(negedge clk);
  endtask

  function automatic logic [47:0] pack_row(logic [15:0] e0, logic [15:0] e1, logic [15:0] e2);
    return {e2, e1, e0};
  endfunction

  task automatic program_camera(int mode);
    logic [47:0] rows [3];
    logic [31:0] tr [3];
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0: begin
          rows[i] = '0; rows[i][16*i +: 16] = 16'd4096; tr[i] = '0;
        end
        1: begin
          rows[i] = {3{16'h7fff}}; tr[i] = 32'h7fffffff;
        end
        2: begin
          rows[i] = {3{16'h8000}}; tr[i] = 32'h80000000;
        end
        default: begin
          rows[i] = 48'({$urandom, $urandom}); tr[i] = $urandom;
        end
      endcase
    end
    write_reg(CfgRotRow0, rows[0]);
    write_reg(CfgRotRow1, rows[1]);
    write_reg(CfgRotRow2, rows[2]);
    write_reg(CfgTransX, {16'hdead, tr[0]});
    write_reg(CfgTransY, {16'h0, tr[1]});
    write_reg(CfgTransZ, {16'hffff, tr[2]});
  endtask

  initial begin
    int phase_pct [4] = '{0, 47, 0, 31};
    logic [15:0] ext [4] = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff};
    logic [15:0] turn [6] = '{16'd0, 16'd1024, 16'd2048, 16'd3072, 16'hf123, 16'd4095};
    start = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0; idle_pct = 0;
    ang = '{default: '0}; scl = '{default: '0}; pos = '{default: '0};
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset camera, then directed nodes
    for (int i = 0; i < 6; i++)
      send_node('{turn[i], turn[(i + 1) % 6], turn[(i + 2) % 6]},
                '{16'd0, 16'd0, 16'd0}, '{ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4]});
    for (int i = 0; i < 4; i++)
      send_node('{16'd300, 16'd1500, 16'd3500}, '{ext[i], ext[(i + 1) % 4], ext[(i + 3) % 4]},
                '{ext[i], ext[i], ext[i]});
    send_node('{16'd0, 16'd0, 16'd0}, '{16'd0, 16'd0, 16'd1}, '{16'd1, 16'd2, 16'd3});
    drain();

    for (int m = 1; m <= 2; m++) begin
      program_camera(m);
      write_raw(3'd6, '1);
      write_raw(3'd7, '1);
      for (int i = 0; i < 4; i++)
        send_node('{ext[i], ext[3 - i], ext[(i + 2) % 4]}, '{ext[i], ext[i], ext[i]},
                  '{ext[i], ext[(i + 1) % 4], ext[3 - i]});
      drain();
    end

    for (int ph = 0; ph < 8; ph++) begin
      program_camera(ph == 0 ? 0 : (ph == 5 ? 1 : (ph == 6 ? 2 : 3)));
      idle_pct = phase_pct[ph % 4];
      for (int n = 0; n < 140; n++) begin
        send_random_node();
        if (n == 70 && ph == 2) drain();
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
